>>> rtl/core/vcfgp_pkg.sv
// ----------------------------------------------------------------------------
// vcfgp_pkg
// shared types and character constants of the vcf genotype field parser
// ----------------------------------------------------------------------------
package vcfgp_pkg;

  // text characters
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PIPE  = 8'h7C;

  // fixed field numbers
  localparam logic [16:0] FIELD_POS    = 17'd2;
  localparam logic [16:0] FIELD_ALT    = 17'd5;
  localparam logic [16:0] FIELD_SAMPLE = 17'd10;

  localparam logic [30:0] POS_MAX       = 31'h7FFF_FFFF;
  localparam logic [15:0] COMMA_RESET   = 16'd2;

  // register map
  localparam int unsigned APB_ADDR_W        = 2;
  localparam logic [1:0]  ADDR_SAMPLE_COUNT = 2'd0;
  localparam logic [15:0] SAMPLE_COUNT_RST  = 16'd1;

  typedef enum logic {
    KIND_GENOTYPE = 1'b0,
    KIND_RECORD   = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } byte_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] sample_index;
    logic [15:0] left_allele;
    logic        left_missing;
    logic [15:0] right_allele;
    logic        right_missing;
    logic        phased;
    logic [30:0] position;
    logic [15:0] allele_count;
    logic [31:0] record_index;
    logic        last;
  } result_t;

  // one queue entry: everything a single byte produced
  typedef struct packed {
    logic        geno_v;
    logic        rec_v;
    logic [15:0] sample_index;
    logic [15:0] left_allele;
    logic        left_missing;
    logic [15:0] right_allele;
    logic        right_missing;
    logic        phased;
    logic [30:0] position;
    logic [15:0] allele_count;
    logic [31:0] record_index;
  } entry_t;

  // queue status toward front and back
  typedef struct packed {
    logic space;
    logic valid;
  } queue_status_t;

endpackage

>>> rtl/core/vcfgp_stream_if.sv
// ----------------------------------------------------------------------------
// vcfgp_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface vcfgp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/vcf_record_genotype_parser_core.sv
// ----------------------------------------------------------------------------
// vcf_record_genotype_parser_core
// streaming vcf text parser emitting genotype and record results
// ----------------------------------------------------------------------------
// usage
//   byte_i carries the vcf text, one character per transaction; newline ends
//   a line. result_o carries genotype results (one per parsed sample column,
//   as the column ends) and a record result at each data line end.
//   sample_count (apb, byte address 0) sets how many sample columns are read.
// throughput
//   one byte per cycle while the event queue has room. a byte that ends the last sample column of a line
//   makes two results, which leave as two result_o transactions.
// result path
//   a result is written into the event queue when its byte is taken and is offered on result_o from there.
// stall behavior
//   a two-entry event queue sits between the parser and the result side;
//   byte_i.ready drops whenever both entries are held, by a stalled
//   receiver or while a two-result entry drains. bytes that make no result still wait for queue room then.
// reset
//   clears the queue, the line parser and the record counter; sample_count
//   returns to 1. no clearing pass, bytes are taken right after reset.
// ----------------------------------------------------------------------------
module vcf_record_genotype_parser_core #(
  parameter int unsigned ALLELE_BITS = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  vcfgp_stream_if.sink                        byte_i,
  vcfgp_stream_if.source                      result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vcfgp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import vcfgp_pkg::*;

  logic [15:0]   sample_count_q;
  logic          cfg_wr;

  // front to queue
  logic          push;
  entry_t        push_entry;
  // queue to back
  logic          pop;
  entry_t        head;
  queue_status_t q_status;

  // apb register: write in the access phase, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_SAMPLE_COUNT);
  assign prdata = (paddr == ADDR_SAMPLE_COUNT) ? {16'd0, sample_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
    end else if (cfg_wr) begin
      sample_count_q <= pwdata[15:0];
    end
  end

  // parser: line mode, field counting, digit accumulation
  vcfgp_front #(
    .ALLELE_BITS (ALLELE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_i         (byte_i),
    .sample_count_i (sample_count_q),
    .q_status_i     (q_status),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // event queue, doubles as the output register
  vcfgp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .status_o (q_status),
    .head_o   (head)
  );

  // result sequencer: genotype first, then record when both are pending
  vcfgp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .head_i     (head),
    .pop_o      (pop),
    .result_o   (result_o)
  );

endmodule

>>> rtl/core/vcfgp_front.sv
// ----------------------------------------------------------------------------
// vcfgp_front
// per-byte line and field parser, pushes genotype and record events
// ----------------------------------------------------------------------------
module vcfgp_front #(
  parameter int unsigned ALLELE_BITS = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  vcfgp_stream_if.sink             byte_i,
  input  logic [15:0]              sample_count_i,
  input  vcfgp_pkg::queue_status_t q_status_i,
  output logic                     push_o,
  output vcfgp_pkg::entry_t        entry_o
);
  import vcfgp_pkg::*;

  localparam int unsigned AW  = (ALLELE_BITS > 16) ? 16 : ALLELE_BITS;
  localparam int unsigned AAW = AW + 4;
  localparam logic [AW-1:0] ALLELE_MAX = '1;
  localparam logic [24:0]   SAMPLE_LIM = 25'(1) << SAMPLE_BITS;

  typedef enum logic [1:0] {
    LM_START,
    LM_DATA,
    LM_SKIP
  } line_mode_e;

  typedef enum logic [2:0] {
    PH_LSTART,
    PH_LDIG,
    PH_LDONE,
    PH_RSTART,
    PH_RDIG,
    PH_IGNORE
  } gt_phase_e;

  line_mode_e      mode_q, mode_d;
  gt_phase_e       phase_q, phase_d, ph;
  logic            in_field_q, in_field_d;
  logic [16:0]     field_q, field_d, fn;
  logic [AW-1:0]   left_q, left_d, lv;
  logic [AW-1:0]   right_q, right_d, rv;
  logic            lmiss_q, lmiss_d, lm;
  logic            rmiss_q, rmiss_d, rm;
  logic            phased_q, phased_d, phs;
  logic [30:0]     pos_q, pos_d;
  logic [15:0]     comma_q, comma_d;
  logic [31:0]     rec_q, rec_d;

  logic            accept, run;
  logic [7:0]      c;
  logic            is_digit;
  logic [3:0]      dval;
  logic [AAW-1:0]  left_acc, right_acc;
  logic [34:0]     pos_acc;
  logic [16:0]     idx;
  logic            geno_hit, rec_hit;

  assign byte_i.ready = q_status_i.space;
  assign accept   = byte_i.valid && byte_i.ready;
  assign c        = byte_i.payload.data_byte;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign dval     = c[3:0];

  // value of the genotype state as this byte sees it (fresh at field start)
  assign fn  = in_field_q ? field_q : ((field_q != '1) ? field_q + 17'd1 : field_q);
  assign ph  = in_field_q ? phase_q : PH_LSTART;
  assign lv  = in_field_q ? left_q : '0;
  assign rv  = in_field_q ? right_q : '0;
  assign lm  = in_field_q ? lmiss_q : 1'b1;
  assign rm  = in_field_q ? rmiss_q : 1'b1;
  assign phs = in_field_q ? phased_q : 1'b0;

  assign left_acc  = AAW'(lv) * AAW'(10) + AAW'(dval);
  assign right_acc = AAW'(rv) * AAW'(10) + AAW'(dval);
  assign pos_acc   = 35'(pos_q) * 35'(10) + 35'(dval);

  assign idx = field_q - FIELD_SAMPLE;

  always_comb begin
    mode_d     = mode_q;
    phase_d    = phase_q;
    in_field_d = in_field_q;
    field_d    = field_q;
    left_d     = left_q;
    right_d    = right_q;
    lmiss_d    = lmiss_q;
    rmiss_d    = rmiss_q;
    phased_d   = phased_q;
    pos_d      = pos_q;
    comma_d    = comma_q;
    rec_d      = rec_q;
    run        = 1'b0;
    geno_hit   = 1'b0;
    rec_hit    = 1'b0;

    if (accept) begin
      unique case (mode_q)
        LM_START: begin
          if (c == CHAR_HASH) begin
            mode_d = LM_SKIP;
          end else if (c != CHAR_NL) begin
            mode_d = LM_DATA;
            run    = 1'b1;
          end
        end
        LM_SKIP: begin
          if (c == CHAR_NL) mode_d = LM_START;
        end
        LM_DATA: run = 1'b1;
        default: mode_d = LM_START;
      endcase
    end

    if (run) begin
      if (c == CHAR_TAB || c == CHAR_NL) begin
        geno_hit = in_field_q && (field_q >= FIELD_SAMPLE) && (idx < {1'b0, sample_count_i})
                   && ({8'd0, idx} < SAMPLE_LIM);
        in_field_d = 1'b0;
        if (c == CHAR_NL) begin
          rec_hit  = 1'b1;
          rec_d    = (rec_q != '1) ? rec_q + 32'd1 : rec_q;
          mode_d   = LM_START;
          field_d  = '0;
          phase_d  = PH_LSTART;
          left_d   = '0;
          right_d  = '0;
          lmiss_d  = 1'b1;
          rmiss_d  = 1'b1;
          phased_d = 1'b0;
          pos_d    = '0;
          comma_d  = COMMA_RESET;
        end
      end else begin
        in_field_d = 1'b1;
        field_d    = fn;
        phase_d    = ph;
        left_d     = lv;
        right_d    = rv;
        lmiss_d    = lm;
        rmiss_d    = rm;
        phased_d   = phs;
        if (fn == FIELD_POS) begin
          // phase doubles as "still in leading digits"
          if (ph == PH_LSTART && is_digit) begin
            pos_d = (pos_acc > 35'(POS_MAX)) ? POS_MAX : pos_acc[30:0];
          end else begin
            phase_d = PH_IGNORE;
          end
        end else if (fn == FIELD_ALT) begin
          if (c == CHAR_COMMA && comma_q != '1) comma_d = comma_q + 16'd1;
        end else if (fn >= FIELD_SAMPLE) begin
          unique case (ph)
            PH_LSTART: begin
              lmiss_d = 1'b0;
              if (c == CHAR_DOT) begin
                lmiss_d = 1'b1;
                phase_d = PH_LDONE;
              end else if (is_digit) begin
                left_d  = AW'(dval);
                phase_d = PH_LDIG;
              end else begin
                phase_d = PH_IGNORE;
              end
            end
            PH_LDIG, PH_LDONE: begin
              if (is_digit && ph == PH_LDIG) begin
                left_d = (left_acc > AAW'(ALLELE_MAX)) ? ALLELE_MAX : left_acc[AW-1:0];
              end else if (c == CHAR_PIPE || c == CHAR_SLASH) begin
                phased_d = phs | (c == CHAR_PIPE);
                rmiss_d  = 1'b0;
                right_d  = '0;
                phase_d  = PH_RSTART;
              end else begin
                phase_d = PH_IGNORE;
              end
            end
            PH_RSTART: begin
              if (c == CHAR_DOT) begin
                rmiss_d = 1'b1;
                phase_d = PH_IGNORE;
              end else if (is_digit) begin
                right_d = AW'(dval);
                phase_d = PH_RDIG;
              end else begin
                phase_d = PH_IGNORE;
              end
            end
            PH_RDIG: begin
              if (is_digit) begin
                right_d = (right_acc > AAW'(ALLELE_MAX)) ? ALLELE_MAX : right_acc[AW-1:0];
              end else begin
                phase_d = PH_IGNORE;
              end
            end
            default: phase_d = PH_IGNORE;
          endcase
        end
      end
    end
  end

  always_comb begin
    push_o                = geno_hit || rec_hit;
    entry_o.geno_v        = geno_hit;
    entry_o.rec_v         = rec_hit;
    entry_o.sample_index  = idx[15:0];
    entry_o.left_allele   = 16'(left_q);
    entry_o.left_missing  = lmiss_q;
    entry_o.right_allele  = 16'(right_q);
    entry_o.right_missing = rmiss_q;
    entry_o.phased        = phased_q;
    entry_o.position      = pos_q;
    entry_o.allele_count  = comma_q;
    entry_o.record_index  = rec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= LM_START;
      phase_q    <= PH_LSTART;
      in_field_q <= 1'b0;
      field_q    <= '0;
      left_q     <= '0;
      right_q    <= '0;
      lmiss_q    <= 1'b1;
      rmiss_q    <= 1'b1;
      phased_q   <= 1'b0;
      pos_q      <= '0;
      comma_q    <= COMMA_RESET;
      rec_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      in_field_q <= in_field_d;
      field_q    <= field_d;
      left_q     <= left_d;
      right_q    <= right_d;
      lmiss_q    <= lmiss_d;
      rmiss_q    <= rmiss_d;
      phased_q   <= phased_d;
      pos_q      <= pos_d;
      comma_q    <= comma_d;
      rec_q      <= rec_d;
    end
  end

endmodule

>>> rtl/core/vcfgp_queue.sv
// ----------------------------------------------------------------------------
// vcfgp_queue
// two-entry event queue between parser and result sequencer
// ----------------------------------------------------------------------------
module vcfgp_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  vcfgp_pkg::entry_t        entry_i,
  input  logic                     pop_i,
  output vcfgp_pkg::queue_status_t status_o,
  output vcfgp_pkg::entry_t        head_o
);
  import vcfgp_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign status_o.space = (count_q != 2'd2);
  assign status_o.valid = (count_q != 2'd0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/vcfgp_back.sv
// ----------------------------------------------------------------------------
// vcfgp_back
// turns queued events into one or two result transactions
// ----------------------------------------------------------------------------
module vcfgp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vcfgp_pkg::queue_status_t q_status_i,
  input  vcfgp_pkg::entry_t        head_i,
  output logic                     pop_o,
  vcfgp_stream_if.source           result_o
);
  import vcfgp_pkg::*;

  logic second_q, second_d;
  logic send_rec, hs;

  // record part goes out alone, or after the genotype part
  assign send_rec = !head_i.geno_v || second_q;
  assign hs       = result_o.valid && result_o.ready;
  assign pop_o    = hs && (send_rec || !head_i.rec_v);

  always_comb begin
    result_o.valid                 = q_status_i.valid;
    result_o.payload.record_index  = head_i.record_index;
    if (send_rec) begin
      result_o.payload.result_kind   = KIND_RECORD;
      result_o.payload.sample_index  = '0;
      result_o.payload.left_allele   = '0;
      result_o.payload.left_missing  = 1'b0;
      result_o.payload.right_allele  = '0;
      result_o.payload.right_missing = 1'b0;
      result_o.payload.phased        = 1'b0;
      result_o.payload.position      = head_i.position;
      result_o.payload.allele_count  = head_i.allele_count;
      result_o.payload.last          = 1'b1;
    end else begin
      result_o.payload.result_kind   = KIND_GENOTYPE;
      result_o.payload.sample_index  = head_i.sample_index;
      result_o.payload.left_allele   = head_i.left_allele;
      result_o.payload.left_missing  = head_i.left_missing;
      result_o.payload.right_allele  = head_i.right_allele;
      result_o.payload.right_missing = head_i.right_missing;
      result_o.payload.phased        = head_i.phased;
      result_o.payload.position      = '0;
      result_o.payload.allele_count  = '0;
      result_o.payload.last          = !head_i.rec_v;
    end
  end

  always_comb begin
    second_d = second_q;
    if (pop_o) begin
      second_d = 1'b0;
    end else if (hs) begin
      second_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
    end
  end

endmodule

>>> rtl/core/vcfgp_checker.sv
// ----------------------------------------------------------------------------
// vcfgp_checker
// port-level checks of the vcf genotype parser, bound to the top level
// ----------------------------------------------------------------------------
module vcfgp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [vcfgp_pkg::APB_ADDR_W-1:0] paddr,
  input logic [31:0]                      pwdata,
  input logic [31:0]                      prdata,
  input logic                             res_valid,
  input logic                             res_ready,
  input vcfgp_pkg::result_t               res_payload
);
  import vcfgp_pkg::*;

  // nothing pending right out of reset
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !res_valid)
    else $error("result offered right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_payload))
    else $error("stalled result changed");

  // genotype that is not last is followed at once by its record result
  a_geno_then_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && (res_payload.result_kind == KIND_GENOTYPE)
      && !res_payload.last
    |=> res_valid && (res_payload.result_kind == KIND_RECORD))
    else $error("record result missing after genotype");

  // register readback follows a write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr == ADDR_SAMPLE_COUNT)
      ##1 (paddr == ADDR_SAMPLE_COUNT)
    |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("sample_count readback mismatch");

endmodule

bind vcf_record_genotype_parser_core vcfgp_checker u_vcfgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .res_valid   (result_o.valid),
  .res_ready   (result_o.ready),
  .res_payload (result_o.payload)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// regression for the vcf genotype field parser: text bytes (directed lines,
// then random records, headers and noise) go in through a valid/ready channel
// with random gaps, results are checked field by field against a predictor of
// the line parser, across several sample_count settings written over apb
// ----------------------------------------------------------------------------
module testbench;

  import vcfgp_pkg::*;

  // predictor state encodings
  typedef enum logic [2:0] {
    GT_LSTART,
    GT_LDIG,
    GT_LDONE,
    GT_RSTART,
    GT_RDIG,
    GT_IGNORE
  } gt_phase_e;

  typedef enum logic [1:0] {
    LN_START,
    LN_DATA,
    LN_SKIP
  } line_mode_e;

  localparam logic [16:0] FIELD_MAX   = 17'h1FFFF;
  localparam logic [15:0] ALLELE_MAX  = 16'hFFFF;
  localparam logic [15:0] ALT_MAX     = 16'hFFFF;
  localparam logic [31:0] RECORD_MAX  = 32'hFFFF_FFFF;
  localparam int unsigned HOLD_CYCLES = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vcfgp_stream_if #(.payload_t(byte_t))   byte_if ();
  vcfgp_stream_if #(.payload_t(result_t)) result_if ();

  vcf_record_genotype_parser_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // text waiting to be sent and results the parser predictor expects
  logic [7:0]  pending_text[$];
  result_t     predicted_results[$];

  // traffic shaping
  logic        idle_on = 1'b0;
  logic        send_hold = 1'b0;
  logic        recv_blocked = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  event        recv_hold_ev;

  // bookkeeping
  int unsigned text_pushed = 0;
  int unsigned bytes_taken = 0;
  int unsigned geno_checked = 0;
  int unsigned rec_checked = 0;
  int unsigned mismatches = 0;

  // line parser predictor state
  logic [15:0] samples_cfg;
  logic [16:0] fld_num;
  logic [2:0]  fld_chars;
  gt_phase_e   gt_phase;
  logic [15:0] left_val;
  logic [15:0] right_val;
  logic        left_miss;
  logic        right_miss;
  logic        is_phased;
  logic [30:0] pos_val;
  logic [15:0] alt_alleles;
  logic [31:0] rec_count;
  line_mode_e  ln_mode;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  // decimal accumulate with saturation
  function automatic logic [31:0] dec_accum(logic [31:0] acc, logic [7:0] c, logic [31:0] lim);
    logic [63:0] n;
    n = 64'(acc) * 64'd10 + 64'(c) - 64'(CHAR_ZERO);
    return (n > 64'(lim)) ? lim : n[31:0];
  endfunction

  function automatic void clear_line();
    fld_num     = '0;
    fld_chars   = '0;
    gt_phase    = GT_LSTART;
    left_val    = '0;
    right_val   = '0;
    left_miss   = 1'b1;
    right_miss  = 1'b1;
    is_phased   = 1'b0;
    pos_val     = '0;
    alt_alleles = COMMA_RESET;
    ln_mode     = LN_START;
  endfunction

  function automatic void genotype_char(logic [7:0] c);
    case (gt_phase)
      GT_LSTART: begin
        left_miss = 1'b0;
        if (c == CHAR_DOT) begin
          left_miss = 1'b1;
          gt_phase  = GT_LDONE;
        end else if (is_digit(c)) begin
          left_val = 16'(c - CHAR_ZERO);
          gt_phase = GT_LDIG;
        end else begin
          gt_phase = GT_IGNORE;
        end
      end
      GT_LDIG, GT_LDONE: begin
        if (is_digit(c) && gt_phase == GT_LDIG) begin
          left_val = 16'(dec_accum(32'(left_val), c, 32'(ALLELE_MAX)));
        end else if (c == CHAR_PIPE || c == CHAR_SLASH) begin
          if (c == CHAR_PIPE) is_phased = 1'b1;
          right_miss = 1'b0;
          right_val  = '0;
          gt_phase   = GT_RSTART;
        end else begin
          gt_phase = GT_IGNORE;
        end
      end
      GT_RSTART: begin
        if (c == CHAR_DOT) begin
          right_miss = 1'b1;
          gt_phase   = GT_IGNORE;
        end else if (is_digit(c)) begin
          right_val = 16'(c - CHAR_ZERO);
          gt_phase  = GT_RDIG;
        end else begin
          gt_phase = GT_IGNORE;
        end
      end
      GT_RDIG: begin
        if (is_digit(c)) right_val = 16'(dec_accum(32'(right_val), c, 32'(ALLELE_MAX)));
        else gt_phase = GT_IGNORE;
      end
      default: ;
    endcase
  endfunction

  // advance the line parser by one accepted byte, queue what it emits
  function automatic void parse_text_byte(logic [7:0] c);
    result_t geno;
    result_t rec;
    logic    have_geno;
    have_geno = 1'b0;
    if (ln_mode == LN_START) begin
      if (c == CHAR_NL) return;
      ln_mode = (c == CHAR_HASH) ? LN_SKIP : LN_DATA;
    end
    if (ln_mode == LN_SKIP) begin
      if (c == CHAR_NL) ln_mode = LN_START;
      return;
    end

    if (c == CHAR_TAB || c == CHAR_NL) begin
      // a sample column closes
      if (fld_chars != '0 && fld_num >= FIELD_SAMPLE
          && (fld_num - FIELD_SAMPLE) < samples_cfg) begin
        geno               = '0;
        geno.result_kind   = KIND_GENOTYPE;
        geno.sample_index  = 16'(fld_num - FIELD_SAMPLE);
        geno.left_allele   = left_val;
        geno.left_missing  = left_miss;
        geno.right_allele  = right_val;
        geno.right_missing = right_miss;
        geno.phased        = is_phased;
        geno.record_index  = rec_count;
        have_geno          = 1'b1;
      end
      fld_chars = '0;
      if (c == CHAR_NL) begin
        rec              = '0;
        rec.result_kind  = KIND_RECORD;
        rec.position     = pos_val;
        rec.allele_count = alt_alleles;
        rec.record_index = rec_count;
        rec.last         = 1'b1;
        if (have_geno) predicted_results.push_back(geno);
        predicted_results.push_back(rec);
        if (rec_count != RECORD_MAX) rec_count++;
        clear_line();
      end else if (have_geno) begin
        geno.last = 1'b1;
        predicted_results.push_back(geno);
      end
      return;
    end

    // first character of a new field
    if (fld_chars == '0) begin
      if (fld_num != FIELD_MAX) fld_num++;
      gt_phase   = GT_LSTART;
      left_val   = '0;
      right_val  = '0;
      left_miss  = 1'b1;
      right_miss = 1'b1;
      is_phased  = 1'b0;
    end
    if (fld_chars < 3'd7) fld_chars++;

    if (fld_num == FIELD_POS) begin
      if (gt_phase == GT_LSTART && is_digit(c)) begin
        pos_val = 31'(dec_accum(32'(pos_val), c, 32'(POS_MAX)));
      end else begin
        gt_phase = GT_IGNORE;
      end
    end else if (fld_num == FIELD_ALT) begin
      if (c == CHAR_COMMA && alt_alleles != ALT_MAX) alt_alleles++;
    end else if (fld_num >= FIELD_SAMPLE) begin
      genotype_char(c);
    end
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // byte driver: offers queued text, with random gaps after accepted transactions while idle_on is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        parse_text_byte(byte_if.payload.data_byte);
        bytes_taken++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          byte_if.valid <= 1'b0;
        end else if (!send_hold && pending_text.size() != 0) begin
          byte_if.valid             <= 1'b1;
          byte_if.payload.data_byte <= pending_text.pop_front();
          if (idle_on) send_gap = draw_gap();
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (predicted_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual kind %0d record %0d",
               $time, got.result_kind, got.record_index);
      return;
    end
    want = predicted_results.pop_front();
    if (want.result_kind == KIND_RECORD) rec_checked++;
    else geno_checked++;
    compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    compare_field("sample_index", 32'(want.sample_index), 32'(got.sample_index));
    compare_field("left_allele", 32'(want.left_allele), 32'(got.left_allele));
    compare_field("left_missing", 32'(want.left_missing), 32'(got.left_missing));
    compare_field("right_allele", 32'(want.right_allele), 32'(got.right_allele));
    compare_field("right_missing", 32'(want.right_missing), 32'(got.right_missing));
    compare_field("phased", 32'(want.phased), 32'(got.phased));
    compare_field("position", 32'(want.position), 32'(got.position));
    compare_field("allele_count", 32'(want.allele_count), 32'(got.allele_count));
    compare_field("record_index", want.record_index, got.record_index);
    compare_field("last", 32'(want.last), 32'(got.last));
  endfunction

  // result monitor with random receiver stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) check_result(result_if.payload);
      if (recv_blocked) begin
        result_if.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 2) == 0) recv_stall = draw_gap();
      end
    end
  end

  // long receiver hold-off, counted on its own
  initial begin
    forever begin
      @(recv_hold_ev);
      @(negedge clk_i);
      recv_blocked = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      recv_blocked = 1'b0;
    end
  end

  // text builders
  function automatic void push_byte(logic [7:0] b);
    pending_text.push_back(b);
    text_pushed++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_token(int unsigned n);
    repeat (n) push_byte(8'($urandom_range(8'h21, 8'h7E)));
  endfunction

  function automatic void push_digits(int unsigned n);
    repeat (n) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_position();
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r == 0) push_byte("+");
    else if (r == 1) push_byte("-");
    else if (r == 2) push_byte(" ");
    push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9));
    if ($urandom_range(0, 7) == 0) push_token(2);
  endfunction

  function automatic void push_alt();
    push_token(1);
    repeat ($urandom_range(0, 4)) begin
      push_byte(CHAR_COMMA);
      if ($urandom_range(0, 3) != 0) push_token(1);
    end
  endfunction

  function automatic void push_genotype();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) push_digits(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7)
                                                         : $urandom_range(1, 2));
    else if (r < 17) push_byte(CHAR_DOT);
    else push_token(1);
    r = $urandom_range(0, 19);
    if (r < 9) push_byte(CHAR_PIPE);
    else if (r < 17) push_byte(CHAR_SLASH);
    else if (r < 19) return;
    else push_token(1);
    r = $urandom_range(0, 19);
    if (r < 13) push_digits(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7)
                                                         : $urandom_range(1, 2));
    else if (r < 17) push_byte(CHAR_DOT);
    else if (r < 19) push_token(1);
    if ($urandom_range(0, 4) == 0) begin
      push_byte(":");
      push_token(2);
    end
  endfunction

  // one data record: nine fixed columns, then sample columns, sometimes cut short
  function automatic void push_record_line();
    int unsigned top;
    int unsigned n_fields;
    top = (samples_cfg > 8) ? 8 : samples_cfg;
    n_fields = 9 + $urandom_range(0, top + 2);
    if ($urandom_range(0, 9) == 0) n_fields = $urandom_range(1, 9);
    if ($urandom_range(0, 7) == 0) push_byte(CHAR_TAB);
    for (int f = 1; f <= n_fields; f++) begin
      if (f > 1) begin
        push_byte(CHAR_TAB);
        if ($urandom_range(0, 9) == 0) push_byte(CHAR_TAB);
      end
      if (f == 2) push_position();
      else if (f == 5) push_alt();
      else if (f >= 10) push_genotype();
      else push_token($urandom_range(1, 4));
    end
    if ($urandom_range(0, 7) == 0) push_byte(CHAR_TAB);
    push_byte(CHAR_NL);
  endfunction

  function automatic void push_random_line();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      push_byte(CHAR_HASH);
      push_token($urandom_range(0, 10));
      push_byte(CHAR_NL);
    end else if (r < 10) begin
      push_byte(CHAR_NL);
    end else if (r < 18) begin
      // raw noise, any byte value
      repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
      push_byte(CHAR_NL);
    end else begin
      push_record_line();
    end
  endfunction

  function automatic void push_lines(int unsigned budget);
    int unsigned goal;
    goal = text_pushed + budget;
    while (text_pushed < goal) push_random_line();
  endfunction

  // all text taken and every result back, plus the parser's own latency
  task automatic wait_idle();
    while (pending_text.size() != 0 || byte_if.valid || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_sample_count(logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SAMPLE_COUNT;
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    samples_cfg = value;
    @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] mid_count;
    byte_if.valid     = 1'b0;
    byte_if.payload   = '0;
    result_if.ready   = 1'b0;
    samples_cfg       = SAMPLE_COUNT_RST;
    rec_count         = '0;
    clear_line();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // header, empty line, leading tab, signed position, saturated position
    push_text("#fileformat\n\n\t#1\t+5\t.\tA\tC,G,T\t.\t.\t.\tGT\t12|7\t3/4\n");
    push_text("1\t4294967299x\t.\tA\tC\t.\t.\t.\tGT\t1\n");
    wait_idle();

    // missing alleles, junk right allele, allele saturation, odd bytes, extra column
    write_sample_count(16'd4);
    push_text("c\t123\ti\tr\t,,\tq\tf\ti\tg\t./.\t.|x\t99999/.\t");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h80);
    push_text("\t\t0|5\n2\t7\tshort\n");
    wait_idle();

    // random traffic with a long receiver hold while text keeps coming
    idle_on = 1'b1;
    push_lines(200);
    -> recv_hold_ev;
    push_lines(250);
    wait_idle();

    // no samples parsed, no idling at all
    write_sample_count(16'd0);
    idle_on = 1'b0;
    push_lines(300);
    wait_idle();

    // every column parsed, sender pauses until all results are back
    write_sample_count(16'hFFFF);
    idle_on = 1'b1;
    push_lines(200);
    send_hold = 1'b1;
    while (byte_if.valid || predicted_results.size() != 0) @(negedge clk_i);
    send_hold = 1'b0;
    push_lines(200);
    wait_idle();

    mid_count = 16'($urandom_range(1, 8));
    write_sample_count(mid_count);
    push_lines(400);
    wait_idle();

    write_sample_count(16'd2);
    idle_on = 1'b0;
    push_lines(250);
    // unfinished line at the end produces nothing
    push_text("7\t42\t");
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("%0d text bytes sent, %0d genotype and %0d record results checked",
             bytes_taken, geno_checked, rec_checked);
    $display("sample_count settings 1, 4, 0, 65535, %0d, 2 with receiver hold and sender pause",
             mid_count);
    if (mismatches == 0) begin
      $display("vcf_record_genotype_parser_core regression: pass");
    end else begin
      $display("vcf_record_genotype_parser_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", predicted_results.size());
    $display("vcf_record_genotype_parser_core regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/vcfgp_pkg.sv
rtl/core/vcfgp_stream_if.sv
rtl/core/vcfgp_front.sv
rtl/core/vcfgp_queue.sv
rtl/core/vcfgp_back.sv
rtl/core/vcf_record_genotype_parser_core.sv
rtl/core/vcfgp_checker.sv
test/testbench.sv
